// ===== src/jittered_exponential_backoff_defines.svh =====
// Assertion helpers for the checker file.
`ifndef JITTERED_EXPONENTIAL_BACKOFF_DEFINES_SVH
`define JITTERED_EXPONENTIAL_BACKOFF_DEFINES_SVH

// Property sampled on aclk, ignored while reset is asserted.
`define JEB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Property sampled on aclk, also checked through reset.
`define JEB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== src/jeb_pkg.sv =====
package jeb_pkg;

    localparam int ATTEMPT_BITS = 32;

    localparam logic [31:0] GOLDEN_SEED = 32'h9e37_79b9;

    // register reset values
    localparam logic [31:0] RST_BASE_DELAY = 32'd1000;
    localparam logic [31:0] RST_CAP_DELAY  = 32'd300000;
    localparam logic [31:0] RST_STABLE     = 32'd30000;
    localparam logic [31:0] RST_SEED       = GOLDEN_SEED;

    // register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAP_DELAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEED       = 2'd3;

    // commands
    localparam logic [1:0] CMD_CONNECT = 2'd0;
    localparam logic [1:0] CMD_CHECK   = 2'd1;
    localparam logic [1:0] CMD_NEXT    = 2'd2;

    // x / 5 == (x * DIV5_MUL) >> 34 for any 32-bit x
    localparam logic [31:0] DIV5_MUL   = 32'hCCCC_CCCD;
    localparam int          SPAN_W     = 30;

    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_NOM,
        ST_SPAN,
        ST_DIV,
        ST_WAIT,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] remainder;
    } div_rsp_t;

    function automatic logic [31:0] xorshift32(input logic [31:0] s);
        logic [31:0] x;
        x = (s == 32'd0) ? GOLDEN_SEED : s;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

endpackage

// ===== src/jeb_div.sv =====
// Restoring divider, one quotient bit per cycle; only the remainder is kept.
module jeb_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  jeb_pkg::div_req_t req,
    output jeb_pkg::div_rsp_t rsp
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [jeb_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [jeb_pkg::DIV_W-1:0]     rem_reg, rem_next;
    logic [jeb_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [jeb_pkg::DIV_W-1:0]     dvs_reg, dvs_next;
    logic [jeb_pkg::DIV_W:0]       trial;
    logic [jeb_pkg::DIV_W:0]       diff;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[jeb_pkg::DIV_W-1]};
        diff      = trial - {1'b0, dvs_reg};

        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = jeb_pkg::DIV_CNT_W'(jeb_pkg::DIV_W);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            // remainder stays below divisor, so it fits in DIV_W bits
            rem_next = diff[jeb_pkg::DIV_W] ? trial[jeb_pkg::DIV_W-1:0]
                                             : diff[jeb_pkg::DIV_W-1:0];
            quo_next = {quo_reg[jeb_pkg::DIV_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == jeb_pkg::DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== src/jittered_exponential_backoff.sv =====
// channel   | handshake        | payload
// ----------+------------------+-----------------------------------------
// request   | s_valid/s_ready  | s_cmd, s_now_ms
// result    | m_valid/m_ready  | m_attempt, m_delay_ms, m_reset_done
// config    | cfg_we           | cfg_index, cfg_wdata
//
// Connect, check and unused commands: ST_EVAL, then the result register loads in ST_OUT.
// Next-delay: ST_EVAL, the one-step-per-cycle doubling loop in ST_NOM, ST_SPAN, the
// 32-step serial divider (ST_DIV, ST_WAIT), ST_FIN and ST_OUT, in that order.
// One request in flight; a new one is taken while a result waits on m_ready.
// Synchronous active-low reset, no clearing pass.
module jittered_exponential_backoff (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_cmd,
    input  logic [63:0]                      s_now_ms,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [31:0]                      m_attempt,
    output logic [31:0]                      m_delay_ms,
    output logic                             m_reset_done,
    input  logic                             cfg_we,
    input  logic [jeb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                      cfg_wdata
);

    localparam int AB = jeb_pkg::ATTEMPT_BITS;

    jeb_pkg::state_t state_reg, state_next;

    logic [31:0]    base_reg, cap_reg, stable_reg;
    logic [AB-1:0]  attempt_reg, attempt_next;
    logic [31:0]    rng_reg, rng_next;
    logic [63:0]    since_reg, since_next;
    logic           conn_reg, conn_next;

    logic [1:0]     cmd_reg, cmd_next;
    logic [63:0]    now_reg, now_next;
    logic [AB-1:0]  loop_reg, loop_next;
    logic [31:0]    nom_reg, nom_next;
    logic [jeb_pkg::SPAN_W-1:0] span_reg, span_next;
    logic [31:0]    delay_reg, delay_next;
    logic           rst_reg, rst_next;

    logic           m_valid_reg, m_valid_next;
    logic [31:0]    m_attempt_reg, m_attempt_next;
    logic [31:0]    m_delay_reg, m_delay_next;
    logic           m_rst_reg, m_rst_next;

    logic [63:0]    elapsed;
    logic           stable_hit;
    logic [AB-1:0]  att_new;
    logic [63:0]    prod;
    logic [32:0]    jit;

    jeb_pkg::div_req_t div_req;
    jeb_pkg::div_rsp_t div_rsp;

    jeb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        state_next     = state_reg;
        attempt_next   = attempt_reg;
        rng_next       = rng_reg;
        since_next     = since_reg;
        conn_next      = conn_reg;
        cmd_next       = cmd_reg;
        now_next       = now_reg;
        loop_next      = loop_reg;
        nom_next       = nom_reg;
        span_next      = span_reg;
        delay_next     = delay_reg;
        rst_next       = rst_reg;
        m_valid_next   = m_valid_reg;
        m_attempt_next = m_attempt_reg;
        m_delay_next   = m_delay_reg;
        m_rst_next     = m_rst_reg;

        div_req.start    = 1'b0;
        div_req.dividend = rng_reg;
        div_req.divisor  = {1'b0, span_reg, 1'b1};

        elapsed    = now_reg - since_reg;
        stable_hit = conn_reg && (now_reg >= since_reg) && (elapsed >= {32'd0, stable_reg});
        att_new    = stable_hit ? '0 : attempt_reg;
        if (att_new != '1) begin
            att_new = att_new + 1'b1;
        end
        prod = nom_reg * jeb_pkg::DIV5_MUL;
        jit  = {1'b0, nom_reg} - {3'd0, span_reg} + {1'b0, div_rsp.remainder};

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            jeb_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_cmd;
                    now_next   = s_now_ms;
                    state_next = jeb_pkg::ST_EVAL;
                end
            end
            jeb_pkg::ST_EVAL: begin
                rst_next   = 1'b0;
                delay_next = '0;
                state_next = jeb_pkg::ST_OUT;
                case (cmd_reg)
                    jeb_pkg::CMD_CONNECT: begin
                        if (!conn_reg) begin
                            conn_next  = 1'b1;
                            since_next = now_reg;
                        end
                    end
                    jeb_pkg::CMD_CHECK: begin
                        if (stable_hit) begin
                            attempt_next = '0;
                            since_next   = now_reg;
                            rst_next     = 1'b1;
                        end
                    end
                    jeb_pkg::CMD_NEXT: begin
                        rst_next     = stable_hit;
                        conn_next    = 1'b0;
                        since_next   = '0;
                        attempt_next = att_new;
                        loop_next    = att_new - 1'b1;
                        nom_next     = base_reg;
                        rng_next     = jeb_pkg::xorshift32(rng_reg);
                        state_next   = jeb_pkg::ST_NOM;
                    end
                    default: begin
                    end
                endcase
            end
            jeb_pkg::ST_NOM: begin
                // one doubling per cycle until attempts run out or cap is reached
                if (loop_reg != '0 && nom_reg < cap_reg) begin
                    if (nom_reg > (cap_reg >> 1)) begin
                        nom_next   = cap_reg;
                        state_next = jeb_pkg::ST_SPAN;
                    end else begin
                        nom_next  = {nom_reg[30:0], 1'b0};
                        loop_next = loop_reg - 1'b1;
                    end
                end else begin
                    if (nom_reg > cap_reg) begin
                        nom_next = cap_reg;
                    end
                    state_next = jeb_pkg::ST_SPAN;
                end
            end
            jeb_pkg::ST_SPAN: begin
                span_next  = prod[63:34];
                state_next = jeb_pkg::ST_DIV;
            end
            jeb_pkg::ST_DIV: begin
                div_req.start = 1'b1;
                state_next    = jeb_pkg::ST_WAIT;
            end
            jeb_pkg::ST_WAIT: begin
                if (div_rsp.done) begin
                    state_next = jeb_pkg::ST_FIN;
                end
            end
            jeb_pkg::ST_FIN: begin
                delay_next = (jit > {1'b0, cap_reg}) ? cap_reg : jit[31:0];
                state_next = jeb_pkg::ST_OUT;
            end
            jeb_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_attempt_next = 32'(attempt_reg);
                    m_delay_next   = delay_reg;
                    m_rst_next     = rst_reg;
                    state_next     = jeb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = jeb_pkg::ST_IDLE;
            end
        endcase

        // seed write reloads the generator
        if (cfg_we && cfg_index == jeb_pkg::REG_SEED) begin
            rng_next = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= jeb_pkg::ST_IDLE;
            attempt_reg <= '0;
            rng_reg     <= jeb_pkg::RST_SEED;
            since_reg   <= '0;
            conn_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            attempt_reg <= attempt_next;
            rng_reg     <= rng_next;
            since_reg   <= since_next;
            conn_reg    <= conn_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg       <= cmd_next;
        now_reg       <= now_next;
        loop_reg      <= loop_next;
        nom_reg       <= nom_next;
        span_reg      <= span_next;
        delay_reg     <= delay_next;
        rst_reg       <= rst_next;
        m_attempt_reg <= m_attempt_next;
        m_delay_reg   <= m_delay_next;
        m_rst_reg     <= m_rst_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg   <= jeb_pkg::RST_BASE_DELAY;
            cap_reg    <= jeb_pkg::RST_CAP_DELAY;
            stable_reg <= jeb_pkg::RST_STABLE;
        end else if (cfg_we) begin
            case (cfg_index)
                jeb_pkg::REG_BASE_DELAY: base_reg   <= cfg_wdata;
                jeb_pkg::REG_CAP_DELAY:  cap_reg    <= cfg_wdata;
                jeb_pkg::REG_STABLE:     stable_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign s_ready      = (state_reg == jeb_pkg::ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_attempt    = m_attempt_reg;
    assign m_delay_ms   = m_delay_reg;
    assign m_reset_done = m_rst_reg;

endmodule

// ===== src/jeb_checker.sv =====
`include "jittered_exponential_backoff_defines.svh"

module jeb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_attempt,
    input logic [31:0] m_delay_ms,
    input logic        m_reset_done
);

    logic [64:0] m_payload;

    assign m_payload = {m_attempt, m_delay_ms, m_reset_done};

    // a stalled result holds
    `JEB_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_payload), "stalled result changed")

    // one request at a time
    `JEB_ASSERT(a_busy_after_accept, s_valid && s_ready |=> !s_ready, "accepted back to back")

    // a cleared count is at most one after the next-delay increment
    `JEB_ASSERT(a_reset_count, m_valid && m_reset_done |-> m_attempt <= 32'd1, "count not cleared")

    // no result straight out of reset
    `JEB_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind jittered_exponential_backoff jeb_checker u_jeb_checker (.*);
